// ===== rtl/lbdg_pkg.sv =====
// shared types, constants and helper functions of the beam direction generator
`default_nettype none
package lbdg_pkg;

   // cordic datapath width and fixed-point constants
   localparam int CW          = 34;
   localparam int ANG_BITS    = 30;
   localparam int INPUT_SCALE = 12;
   localparam int MAX_STEPS   = 24;
   localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic [30:0]          HALF_PI_Q30 = 31'd1686629713;

   // default parameter values
   localparam int DEF_MAX_CIRCLES   = 4;
   localparam int DEF_CORDIC_STEPS  = 16;
   localparam int DEF_FRACTION_BITS = 15;

   // request classes
   localparam logic [1:0] KIND_REJECT = 2'd0;
   localparam logic [1:0] KIND_CENTER = 2'd1;
   localparam logic [1:0] KIND_RIGHT  = 2'd2;
   localparam logic [1:0] KIND_NORMAL = 2'd3;

   typedef struct packed {
      logic [1:0] circle;
      logic [1:0] kind;
   } cmd_type;

   typedef struct packed {
      logic            start;
      logic            mode_rot;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } cordic_req_type;

   typedef struct packed {
      logic            done;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } cordic_rsp_type;

   function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CW-1:0] r;
      case (idx)
         5'd0:  r = 34'sd843314857;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043837;
         5'd3:  r = 34'sd133525159;
         5'd4:  r = 34'sd67021687;
         5'd5:  r = 34'sd33543516;
         5'd6:  r = 34'sd16775851;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194283;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048576;
         5'd11: r = 34'sd524288;
         5'd12: r = 34'sd262144;
         5'd13: r = 34'sd131072;
         5'd14: r = 34'sd65536;
         5'd15: r = 34'sd32768;
         5'd16: r = 34'sd16384;
         5'd17: r = 34'sd8192;
         5'd18: r = 34'sd4096;
         5'd19: r = 34'sd2048;
         5'd20: r = 34'sd1024;
         5'd21: r = 34'sd512;
         5'd22: r = 34'sd256;
         5'd23: r = 34'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd32767) r = 16'sh7fff;
      else if (v < -64'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lbdg_front.sv =====
// front end: accepts circle requests, classifies them and queues them
`default_nettype none
module lbdg_front #(
   parameter int MAX_CIRCLES = lbdg_pkg::DEF_MAX_CIRCLES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_circle_index,
   input  wire logic [2:0]       circle_count,
   input  wire logic             z_min_zero,
   output logic                  q_valid,
   output lbdg_pkg::cmd_type     q_cmd,
   input  wire logic             q_pop
);
   import lbdg_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic       push, pop;

   always_comb begin
      cls.circle = req_circle_index;
      if ((3'(req_circle_index) >= circle_count) ||
          (int'(req_circle_index) >= MAX_CIRCLES)) begin
         cls.kind = KIND_REJECT;
      end else if (req_circle_index == 2'd0) begin
         cls.kind = KIND_CENTER;
      end else if (z_min_zero) begin
         cls.kind = KIND_RIGHT;
      end else begin
         cls.kind = KIND_NORMAL;
      end
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/lbdg_cordic.sv =====
// shared iterative cordic unit, vectoring and rotation modes
`default_nettype none
module lbdg_cordic #(
   parameter int CORDIC_STEPS = lbdg_pkg::DEF_CORDIC_STEPS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lbdg_pkg::cordic_req_type req,
   output lbdg_pkg::cordic_rsp_type    rsp
);
   import lbdg_pkg::*;

   localparam int STEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [4:0] i_ff, i_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic       mode_ff, mode_in;
   logic       sigma;
   logic signed [CW-1:0] xs, ys, at;

   always_comb begin
      xs    = x_ff >>> i_ff;
      ys    = y_ff >>> i_ff;
      at    = atan_q30(i_ff);
      // positive rotation sense
      sigma = mode_ff ? !z_ff[CW-1] : y_ff[CW-1];
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      i_in = i_ff; busy_in = busy_ff; done_in = 1'b0; mode_in = mode_ff;
      if (req.start) begin
         x_in = req.x; y_in = req.y; z_in = req.z;
         mode_in = req.mode_rot;
         i_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sigma) begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      i_ff    <= i_in;
      mode_ff <= mode_in;
   end

   assign rsp.done = done_ff;
   assign rsp.x    = x_ff;
   assign rsp.y    = y_ff;
   assign rsp.z    = z_ff;
endmodule
`default_nettype wire

// ===== rtl/lbdg_back.sv =====
// back end: elevation, per-beam azimuth rotation, products and result register
`default_nettype none
module lbdg_back #(
   parameter int FRACTION_BITS = lbdg_pkg::DEF_FRACTION_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   input  wire lbdg_pkg::cmd_type       q_cmd,
   output logic                         q_pop,
   input  wire logic [15:0]             min_range,
   input  wire logic [15:0]             circle_spacing_cm,
   output lbdg_pkg::cordic_req_type     cor_req,
   input  wire lbdg_pkg::cordic_rsp_type cor_rsp,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [15:0]           rsp_forward_x,
   output logic signed [15:0]           rsp_right_y,
   output logic signed [15:0]           rsp_up_z,
   output logic [5:0]                   rsp_beam_number,
   output logic                         rsp_in_range,
   output logic                         rsp_last_beam
);
   import lbdg_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_VEC  = 3'd1;
   localparam logic [2:0] S_ROTE = 3'd2;
   localparam logic [2:0] S_ANG  = 3'd3;
   localparam logic [2:0] S_BROT = 3'd4;
   localparam logic [2:0] S_MULY = 3'd5;
   localparam logic [2:0] S_MULZ = 3'd6;
   localparam logic [2:0] S_EMIT = 3'd7;

   localparam int SHIFT = ANG_BITS - FRACTION_BITS;
   localparam logic signed [CW-1:0] ROUND_F = (SHIFT == 0) ? '0 : (CW'(1) << (SHIFT - 1));
   localparam logic signed [15:0]   ONE_VAL =
      (FRACTION_BITS >= 15) ? 16'sh7fff : 16'(1 << FRACTION_BITS);
   localparam logic signed [50:0]   ROUND_P = 51'sd1 << 29;

   logic [2:0] state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   logic [5:0] k_ff, k_in;
   logic [1:0] quad_ff, quad_in;
   logic signed [15:0] ec_ff, ec_in, es_ff, es_in;
   logic signed [CW-1:0] ca_ff, ca_in, sa_ff, sa_in;
   logic signed [15:0] ry_ff, ry_in, rz_ff, rz_in;

   logic rv_ff, rv_in;
   logic signed [15:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [5:0] ob_ff, ob_in;
   logic       oi_ff, oi_in, ol_ff, ol_in;

   logic out_free, is_last;
   logic [2:0]  sh;
   logic [5:0]  jmask, j;
   logic [36:0] aprod;
   logic signed [CW-1:0] az;
   logic [17:0] ny;
   logic signed [CW-1:0] mul_op;
   logic signed [49:0]   prod;
   logic signed [50:0]   psum;
   logic signed [15:0]   prnd;

   function automatic logic signed [15:0] to_frac(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] t;
      t = (v + ROUND_F) >>> SHIFT;
      return sat16(64'(t));
   endfunction

   assign out_free = !rv_ff || !rsp_stall;
   assign is_last  = ((7'(k_ff) + 7'd1) == (7'd1 << {cmd_ff.circle, 1'b0}));

   // azimuth angle within a quadrant
   always_comb begin
      sh    = {cmd_ff.circle, 1'b0} - 3'd2;
      jmask = (6'd1 << sh) - 6'd1;
      j     = k_ff & jmask;
      aprod = 37'(j) * 37'(HALF_PI_Q30);
      az    = CW'(aprod >> sh);
      ny    = 18'(circle_spacing_cm) * 18'(cmd_ff.circle);
   end

   // one shared multiplier for the two products
   always_comb begin
      mul_op = (state_ff == S_MULY) ? ca_ff : sa_ff;
      prod   = 50'(es_ff) * 50'(mul_op);
      psum   = 51'(prod) + ROUND_P;
      prnd   = sat16(64'(psum >>> 30));
   end

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; k_in = k_ff; quad_in = quad_ff;
      ec_in = ec_ff; es_in = es_ff; ca_in = ca_ff; sa_in = sa_ff;
      ry_in = ry_ff; rz_in = rz_ff;
      rv_in = rv_ff && rsp_stall;
      ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff; ob_in = ob_ff;
      oi_in = oi_ff; ol_in = ol_ff;
      q_pop = 1'b0;
      cor_req.start    = 1'b0;
      cor_req.mode_rot = 1'b1;
      cor_req.x        = GAIN_Q30;
      cor_req.y        = '0;
      cor_req.z        = cor_rsp.z;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               k_in   = '0;
               case (q_cmd.kind)
                  KIND_REJECT: state_in = S_EMIT;
                  KIND_CENTER: begin
                     ec_in = ONE_VAL; es_in = '0; state_in = S_ANG;
                  end
                  KIND_RIGHT: begin
                     ec_in = '0; es_in = ONE_VAL; state_in = S_ANG;
                  end
                  default: state_in = S_VEC;
               endcase
            end
         end
         S_VEC: begin
            // launch vectoring on the stored circle
            cor_req.start    = 1'b1;
            cor_req.mode_rot = 1'b0;
            cor_req.x        = CW'(min_range) <<< INPUT_SCALE;
            cor_req.y        = CW'(ny) <<< INPUT_SCALE;
            cor_req.z        = '0;
            state_in         = S_ROTE;
         end
         S_ROTE: begin
            if (cor_rsp.done) begin
               if (cmd_ff.kind == KIND_CENTER) begin
                  ec_in    = to_frac(cor_rsp.x);
                  es_in    = to_frac(cor_rsp.y);
                  cmd_in.kind = KIND_NORMAL;
                  state_in = S_ANG;
               end else begin
                  // elevation angle ready: start cos/sin rotation
                  cor_req.start = 1'b1;
                  cor_req.z     = cor_rsp.z;
                  cmd_in.kind   = KIND_CENTER;
               end
            end
         end
         S_ANG: begin
            cor_req.start = 1'b1;
            if (cmd_ff.circle == 2'd0) begin
               cor_req.z = '0;
               quad_in   = 2'd0;
            end else begin
               cor_req.z = az;
               quad_in   = 2'(k_ff >> sh);
            end
            state_in = S_BROT;
         end
         S_BROT: begin
            if (cor_rsp.done) begin
               case (quad_ff)
                  2'd0: begin ca_in = cor_rsp.x;  sa_in = cor_rsp.y;  end
                  2'd1: begin ca_in = -cor_rsp.y; sa_in = cor_rsp.x;  end
                  2'd2: begin ca_in = -cor_rsp.x; sa_in = -cor_rsp.y; end
                  default: begin ca_in = cor_rsp.y; sa_in = -cor_rsp.x; end
               endcase
               state_in = S_MULY;
            end
         end
         S_MULY: begin
            ry_in    = prnd;
            state_in = S_MULZ;
         end
         S_MULZ: begin
            rz_in    = prnd;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rv_in = 1'b1;
               if (cmd_ff.kind == KIND_REJECT) begin
                  ox_in = '0; oy_in = '0; oz_in = '0; ob_in = '0;
                  oi_in = 1'b0; ol_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  ox_in = ec_ff; oy_in = ry_ff; oz_in = rz_ff; ob_in = k_ff;
                  oi_in = 1'b1; ol_in = is_last;
                  if (is_last) begin
                     state_in = S_IDLE;
                  end else begin
                     k_in     = k_ff + 6'd1;
                     state_in = S_ANG;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; k_ff <= k_in; quad_ff <= quad_in;
      ec_ff <= ec_in; es_ff <= es_in; ca_ff <= ca_in; sa_ff <= sa_in;
      ry_ff <= ry_in; rz_ff <= rz_in;
      ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in; ob_ff <= ob_in;
      oi_ff <= oi_in; ol_ff <= ol_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_forward_x   = ox_ff;
   assign rsp_right_y     = oy_ff;
   assign rsp_up_z        = oz_ff;
   assign rsp_beam_number = ob_ff;
   assign rsp_in_range    = oi_ff;
   assign rsp_last_beam   = ol_ff;
endmodule
`default_nettype wire

// ===== rtl/lidar_beam_direction_generator_unit.sv =====
// top level of the lidar beam direction generator
//
//  channel   ports        direction  handshake
//  request   req_*        in         valid / stall
//  result    rsp_*        out        valid / stall
//  csr       csr_*        in         valid / ready (ready tied high)
//
// a normal circle n does its elevation work as vectoring then rotation on the
// shared cordic, then one more rotation on the shared cordic per beam, 4^n beams
// a rejected index gives one result
// reset is synchronous, active high; csr registers return to 100, 10 and 4
// the two-entry request queue lets the front take requests while the back
// waits on a stalled result register
`default_nettype none
module lidar_beam_direction_generator_unit #(
   parameter int MAX_CIRCLES   = lbdg_pkg::DEF_MAX_CIRCLES,
   parameter int CORDIC_STEPS  = lbdg_pkg::DEF_CORDIC_STEPS,
   parameter int FRACTION_BITS = lbdg_pkg::DEF_FRACTION_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_circle_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [15:0] rsp_forward_x,
   output logic signed [15:0] rsp_right_y,
   output logic signed [15:0] rsp_up_z,
   output logic [5:0]       rsp_beam_number,
   output logic             rsp_in_range,
   output logic             rsp_last_beam,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import lbdg_pkg::*;

   // csr register indexes
   localparam logic [1:0] REG_Z_MIN   = 2'd0;
   localparam logic [1:0] REG_SPACING = 2'd1;
   localparam logic [1:0] REG_COUNT   = 2'd2;

   logic [15:0] z_min_ff, z_min_in;
   logic [15:0] spacing_ff, spacing_in;
   logic [2:0]  count_ff, count_in;

   logic           q_valid, q_pop;
   cmd_type        q_cmd;
   cordic_req_type cor_req;
   cordic_rsp_type cor_rsp;

   assign csr_ready = 1'b1;

   // csr writes; an index past the list is dropped
   always_comb begin
      z_min_in   = z_min_ff;
      spacing_in = spacing_ff;
      count_in   = count_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_Z_MIN:   z_min_in   = csr_data;
            REG_SPACING: spacing_in = csr_data;
            REG_COUNT:   count_in   = csr_data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z_min_ff   <= 16'd100;
         spacing_ff <= 16'd10;
         count_ff   <= 3'd4;
      end else begin
         z_min_ff   <= z_min_in;
         spacing_ff <= spacing_in;
         count_ff   <= count_in;
      end
   end

   // front: accept and classify
   lbdg_front #(.MAX_CIRCLES(MAX_CIRCLES)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_circle_index (req_circle_index),
      .circle_count     (count_ff),
      .z_min_zero       (z_min_ff == 16'd0),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop)
   );

   // shared trig unit
   lbdg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cor_req),
      .rsp   (cor_rsp)
   );

   // back: elevation, beams, result register
   lbdg_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .q_pop             (q_pop),
      .min_range         (z_min_ff),
      .circle_spacing_cm (spacing_ff),
      .cor_req           (cor_req),
      .cor_rsp           (cor_rsp),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_forward_x     (rsp_forward_x),
      .rsp_right_y       (rsp_right_y),
      .rsp_up_z          (rsp_up_z),
      .rsp_beam_number   (rsp_beam_number),
      .rsp_in_range      (rsp_in_range),
      .rsp_last_beam     (rsp_last_beam)
   );
endmodule
`default_nettype wire

// ===== verif/tb_lidar_beam_direction_generator_unit.sv =====
// testbench of the lidar beam direction generator: directed and random requests vs a cordic predictor
`default_nettype none
module tb_lidar_beam_direction_generator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // block parameters as built
   localparam int N_CIRCLES = lbdg_pkg::DEF_MAX_CIRCLES;
   localparam int N_STEPS   = lbdg_pkg::DEF_CORDIC_STEPS;
   localparam int FRAC      = lbdg_pkg::DEF_FRACTION_BITS;

   // csr register indexes
   localparam logic [1:0] REG_Z_MIN   = 2'd0;
   localparam logic [1:0] REG_SPACING = 2'd1;
   localparam logic [1:0] REG_COUNT   = 2'd2;

   // fixed-point constants of the angle path
   localparam longint GAIN      = 64'sd652032874;
   localparam longint HALF_PI   = 64'sd1686629713;
   localparam int     SCALE_IN  = 12;
   localparam int     WATCH_MAX = 20000;

   localparam longint ARCTAN [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128};

   typedef struct {
      logic signed [15:0] fwd;
      logic signed [15:0] right;
      logic signed [15:0] up;
      logic [5:0]         number;
      logic               in_range;
      logic               last;
   } beam_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_circle_index;
   logic rsp_valid, rsp_stall;
   logic signed [15:0] rsp_forward_x, rsp_right_y, rsp_up_z;
   logic [5:0] rsp_beam_number;
   logic rsp_in_range, rsp_last_beam;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [15:0] csr_data;

   // mirror of the csr registers
   int unsigned z_min = 100, spacing = 10, count_cfg = 4;

   logic [1:0] pending_circles[$];
   beam_type   beams_due[$];
   int send_idle_pct = 0, recv_stall_pct = 0;
   int errors = 0, quiet_cycles = 0;

   lidar_beam_direction_generator_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // cordic vectoring: angle of (x, y), Q30 radians
   function automatic longint elevation_angle(longint x, longint y);
      longint z = 0, xs, ys;
      for (int i = 0; i < N_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += ARCTAN[i];
         end else begin
            x -= ys; y += xs; z -= ARCTAN[i];
         end
      end
      return z;
   endfunction

   // cordic rotation: cos and sin in Q30
   function automatic void cos_sin(longint a, output longint c, output longint s);
      longint x = GAIN, y = 0, xs, ys;
      for (int i = 0; i < N_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (a >= 0) begin
            x -= ys; y += xs; a -= ARCTAN[i];
         end else begin
            x += ys; y -= xs; a += ARCTAN[i];
         end
      end
      c = x;
      s = y;
   endfunction

   // expected beams of one circle request
   function automatic void predict_circle(logic [1:0] n);
      longint one, el_cos, el_sin, c, s, ca, sa, ang, rem, rnd;
      int unsigned n_beams;
      logic [31:0] phase;
      beam_type b;
      one = clip16(longint'(1) << FRAC);
      rnd = longint'(1) << (30 - FRAC - 1);
      if (n >= count_cfg || n >= N_CIRCLES) begin
         b = '{0, 0, 0, 0, 1'b0, 1'b1};
         beams_due.insert(beams_due.size(), b);
         return;
      end
      if (n == 0) begin
         el_cos = one; el_sin = 0;
      end else if (z_min == 0) begin
         el_cos = 0; el_sin = one;
      end else begin
         ang = elevation_angle(longint'(z_min) << SCALE_IN,
                               (longint'(n) * spacing) << SCALE_IN);
         cos_sin(ang, c, s);
         el_cos = clip16((c + rnd) >>> (30 - FRAC));
         el_sin = clip16((s + rnd) >>> (30 - FRAC));
      end
      n_beams = 1 << (2 * n);
      for (int unsigned k = 0; k < n_beams; k++) begin
         phase = (n == 0) ? 32'd0 : 32'(k << (32 - 2 * n));
         rem = longint'(phase[29:0]);
         ang = (rem * HALF_PI) >>> 30;
         cos_sin(ang, c, s);
         case (phase[31:30])
            2'd0: begin ca = c;  sa = s;  end
            2'd1: begin ca = -s; sa = c;  end
            2'd2: begin ca = -c; sa = -s; end
            default: begin ca = s; sa = -c; end
         endcase
         b.fwd      = 16'(el_cos);
         b.right    = 16'(clip16((el_sin * ca + (longint'(1) << 29)) >>> 30));
         b.up       = 16'(clip16((el_sin * sa + (longint'(1) << 29)) >>> 30));
         b.number   = 6'(k);
         b.in_range = 1'b1;
         b.last     = (k + 1 == n_beams);
         beams_due.insert(beams_due.size(), b);
      end
   endfunction

   // ---------------------------------------------------------------- driver
   // a request leaves the queue only when the previous one was taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_circle_index <= 2'd0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            predict_circle(req_circle_index);
         if (pending_circles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_circle_index <= pending_circles.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // csr writes land in the mirror on the handshake
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            REG_Z_MIN:   z_min = csr_data;
            REG_SPACING: spacing = csr_data;
            REG_COUNT:   count_cfg = csr_data[2:0];
            default: ;
         endcase
         csr_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- monitor
   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      beam_type b;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (beams_due.size() == 0) begin
            report_mismatch("extra result", 1, 0);
         end else begin
            b = beams_due.pop_front();
            if (rsp_forward_x !== b.fwd) report_mismatch("forward_x", rsp_forward_x, b.fwd);
            if (rsp_right_y !== b.right) report_mismatch("right_y", rsp_right_y, b.right);
            if (rsp_up_z !== b.up) report_mismatch("up_z", rsp_up_z, b.up);
            if (rsp_beam_number !== b.number)
               report_mismatch("beam_number", rsp_beam_number, b.number);
            if (rsp_in_range !== b.in_range)
               report_mismatch("in_range", rsp_in_range, b.in_range);
            if (rsp_last_beam !== b.last)
               report_mismatch("last_beam", rsp_last_beam, b.last);
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCH_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ---------------------------------------------------------------- sequence
   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_valid);
   endtask

   task automatic setup(int unsigned z, int unsigned sp, int unsigned cnt);
      write_reg(REG_Z_MIN, 16'(z));
      write_reg(REG_SPACING, 16'(sp));
      write_reg(REG_COUNT, 16'(cnt));
   endtask

   // wait until every request is taken and every beam is back
   task automatic drain();
      do @(posedge clock);
      while (pending_circles.size() > 0 || req_valid || beams_due.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic send(logic [1:0] circles[$]);
      foreach (circles[i]) pending_circles.insert(pending_circles.size(), circles[i]);
      drain();
   endtask

   initial begin
      int unsigned z, sp, cnt;
      logic [1:0] circ[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_circle_index = 2'd0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = 2'd0;
      csr_data = 16'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset config, every circle
      send('{2'd0, 2'd1, 2'd2, 2'd3});
      // zero range gives a right angle
      setup(0, 10, 4);
      send('{2'd1, 2'd2, 2'd0});
      // zero spacing gives a near-zero elevation
      setup(100, 0, 4);
      send('{2'd1, 2'd2});
      // all-ones registers, count above the circle limit
      setup(65535, 65535, 7);
      send('{2'd3, 2'd0, 2'd1});
      // count zero rejects every index
      setup(1, 65535, 0);
      send('{2'd0, 2'd3, 2'd2});
      // count one: only the centre beam passes
      setup(500, 40, 1);
      send('{2'd0, 2'd1, 2'd3});

      // random phases over the idling modes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         z   = ($urandom_range(9) == 0) ? 0 : $urandom_range(65535);
         sp  = ($urandom_range(9) == 0) ? 0 : $urandom_range(65535);
         cnt = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(4, 2);
         if ($urandom_range(1)) begin
            z = $urandom_range(1000);
            sp = $urandom_range(300);
         end
         setup(z, sp, cnt);
         circ.delete();
         // the largest circle is slow, keep it rare
         for (int i = 0; i < 32; i++)
            circ.insert(circ.size(),
                        ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)));
         send(circ);
      end

      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
